// File: sv/npseg_pkg.sv
// Package: region codes and shared types for the nearest-point-on-segment unit.
package npseg_pkg;
   localparam int TBITS = 30;
   typedef enum logic [1:0] {
      REGION_BEFORE = 2'd0,
      REGION_INSIDE = 2'd1,
      REGION_PAST   = 2'd2
   } region_type;
   localparam logic [2:0] CSR_START_X = 3'd0;
   localparam logic [2:0] CSR_START_Y = 3'd1;
   localparam logic [2:0] CSR_START_Z = 3'd2;
   localparam logic [2:0] CSR_END_X   = 3'd3;
   localparam logic [2:0] CSR_END_Y   = 3'd4;
   localparam logic [2:0] CSR_END_Z   = 3'd5;
endpackage

// File: sv/npseg_divider.sv
// Pipelined restoring divider: quotient of num / den, one bit per stage.
module npseg_divider
   import npseg_pkg::*;
#(
   parameter int W = 68,
   parameter int QB = 30
) (
   input  logic          clock,
   input  logic          advance,
   input  logic [W-1:0]  num_in,
   input  logic [W-1:0]  den_in,
   output logic [QB-1:0] quo_out
);
   logic [W:0]    rem_ff [1:QB];
   logic [W-1:0]  den_ff [1:QB];
   logic [QB-1:0] quo_ff [1:QB];
   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic [W:0]    rem_cur;
      logic [W-1:0]  den_cur;
      logic [QB-1:0] quo_cur;
      logic [W+1:0]  shl_in;
      logic          ge_in;
      if (k == 0) begin : g_first
         assign rem_cur = {1'b0, num_in};
         assign den_cur = den_in;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[k];
         assign den_cur = den_ff[k];
         assign quo_cur = quo_ff[k];
      end
      assign shl_in = {rem_cur, 1'b0};
      assign ge_in  = shl_in >= {2'b00, den_cur};
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k+1] <= ge_in ? (W+1)'(shl_in - {2'b00, den_cur}) : shl_in[W:0];
            den_ff[k+1] <= den_cur;
            quo_ff[k+1] <= {quo_cur[QB-2:0], ge_in};
         end
      end
   end
   assign quo_out = quo_ff[QB];
endmodule

// File: sv/npseg_sqrt.sv
// Pipelined bitwise integer square root, one result bit per stage.
module npseg_sqrt #(
   parameter int W = 72,
   parameter int RB = 35
) (
   input  logic          clock,
   input  logic          advance,
   input  logic [W-1:0]  sq_in,
   output logic [RB-1:0] root_out
);
   logic [W-1:0]  sq_ff   [1:RB];
   logic [RB-1:0] root_ff [1:RB];
   for (genvar k = 0; k < RB; k++) begin : g_stage
      localparam int B = RB - 1 - k;
      logic [W-1:0]    sq_cur;
      logic [RB-1:0]   root_cur;
      logic [RB-1:0]   cand_in;
      logic [2*RB-1:0] cc_in;
      if (k == 0) begin : g_first
         assign sq_cur   = sq_in;
         assign root_cur = '0;
      end else begin : g_next
         assign sq_cur   = sq_ff[k];
         assign root_cur = root_ff[k];
      end
      assign cand_in = root_cur | (RB'(1) << B);
      assign cc_in   = cand_in * cand_in;
      always_ff @(posedge clock) begin
         if (advance) begin
            sq_ff[k+1]   <= sq_cur;
            root_ff[k+1] <= ((2*RB > W ? cc_in : (2*RB)'(cc_in)) <= (2*RB)'(sq_cur))
                            ? cand_in : root_cur;
         end
      end
   end
   assign root_out = root_ff[RB];
endmodule

// File: sv/nearest_point_on_segment_3d_unit.sv
// Top level: nearest point on a configured 3D segment, with region and distance.
// Usage:
//   csr_* writes the six segment coordinates (index 0..5: start xyz, end xyz);
//   write only while idle. Reset clears them to zero.
//   req_ words carry a query point {z,y,x} in tdata; rsp_ words carry the
//   nearest point {z,y,x} in tdata and {gap_length, region} in tuser.
//   One word enters per cycle while the pipeline advances. There are 62 register
//   stages: 3 arithmetic stages, TBITS (30) divider stages, 2 stages for the point,
//   COORD_BITS+2 (26) sqrt stages, plus the output register.
//   The whole pipeline advances as one; when rsp_tready is low and the output
//   holds a word, the pipeline freezes, so nothing is lost or repeated.
//   Reset clears all valid bits; no word is presented after reset until one
//   has been accepted.
module nearest_point_on_segment_3d_unit
   import npseg_pkg::*;
#(
   parameter int COORD_BITS = 24,
   parameter int FRAC_BITS  = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic                      csr_we,
   input  logic [2:0]                csr_index,
   input  logic [COORD_BITS-1:0]     csr_wdata,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // x, y, z from the low bits
   input  logic [((3*COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // near_x, near_y, near_z from the low bits
   output logic [((3*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   // region, gap_length from the low bits
   output logic [COORD_BITS+2:0]     rsp_tuser
);
   localparam int C  = COORD_BITS;
   localparam int DW = C + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 2;
   localparam int DV = SW + 1;
   localparam int RB = (SW + 1) / 2;
   localparam int TW = 3 * C;
   localparam int LAT = 2 + TBITS + 2 + RB;
   localparam int FRAC_UNUSED = FRAC_BITS;

   logic signed [C-1:0] s_ff [3];
   logic signed [C-1:0] e_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            s_ff[i] <= '0;
            e_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_X: s_ff[0] <= csr_wdata;
            CSR_START_Y: s_ff[1] <= csr_wdata;
            CSR_START_Z: s_ff[2] <= csr_wdata;
            CSR_END_X:   e_ff[0] <= csr_wdata;
            CSR_END_Y:   e_ff[1] <= csr_wdata;
            CSR_END_Z:   e_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic out_valid_ff;
   logic advance;
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   logic [LAT:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[LAT-1:0], req_tvalid};
   end

   // stage 1: differences
   logic signed [DW-1:0] d1_ff [3];
   logic signed [DW-1:0] v1_ff [3];
   logic signed [C-1:0]  q1_ff [3];
   // stage 2: products
   logic signed [PW-1:0] pd2_ff [3];
   logic signed [PW-1:0] pl2_ff [3];
   logic signed [DW-1:0] d2_ff [3];
   logic signed [C-1:0]  q2_ff [3];
   // stage 3: sums and region
   logic [SW-1:0] dot3_ff, len3_ff;
   region_type    reg3_ff;
   logic signed [DW-1:0] d3_ff [3];
   logic signed [C-1:0]  q3_ff [3];
   logic signed [SW-1:0] dot_in, len_in;
   always_comb begin
      dot_in = '0;
      len_in = '0;
      for (int i = 0; i < 3; i++) begin
         dot_in = dot_in + SW'(pd2_ff[i]);
         len_in = len_in + SW'(pl2_ff[i]);
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            d1_ff[i]  <= DW'(e_ff[i]) - DW'(s_ff[i]);
            v1_ff[i]  <= DW'($signed(req_tdata[i*C +: C])) - DW'(s_ff[i]);
            q1_ff[i]  <= req_tdata[i*C +: C];
            pd2_ff[i] <= d1_ff[i] * v1_ff[i];
            pl2_ff[i] <= d1_ff[i] * d1_ff[i];
            d2_ff[i]  <= d1_ff[i];
            q2_ff[i]  <= q1_ff[i];
            d3_ff[i]  <= d2_ff[i];
            q3_ff[i]  <= q2_ff[i];
         end
         if (dot_in < 0) begin
            reg3_ff <= REGION_BEFORE;
            dot3_ff <= '0;
         end else if (dot_in > len_in) begin
            reg3_ff <= REGION_PAST;
            dot3_ff <= '0;
         end else begin
            reg3_ff <= REGION_INSIDE;
            dot3_ff <= dot_in;
         end
         len3_ff <= len_in;
      end
   end

   // divider: t = dot*2^30/len2 (full when equal)
   logic [TBITS-1:0] quo;
   logic             eq3;
   assign eq3 = (dot3_ff == len3_ff) && (reg3_ff == REGION_INSIDE);
   npseg_divider #(.W(DV), .QB(TBITS)) u_div (
      .clock(clock), .advance(advance),
      .num_in({1'b0, dot3_ff}), .den_in({1'b0, len3_ff}), .quo_out(quo));

   // side delay line alongside divider
   region_type           rg_ff [1:TBITS];
   logic                 eq_ff [1:TBITS];
   logic signed [DW-1:0] dd_ff [1:TBITS][3];
   logic signed [C-1:0]  qq_ff [1:TBITS][3];
   always_ff @(posedge clock) begin
      if (advance) begin
         rg_ff[1] <= reg3_ff;
         eq_ff[1] <= eq3;
         dd_ff[1] <= d3_ff;
         qq_ff[1] <= q3_ff;
         for (int k = 1; k < TBITS; k++) begin
            rg_ff[k+1] <= rg_ff[k];
            eq_ff[k+1] <= eq_ff[k];
            dd_ff[k+1] <= dd_ff[k];
            qq_ff[k+1] <= qq_ff[k];
         end
      end
   end

   // point stage A: |d|*t ; stage B: rounded point and squared gaps
   logic [TBITS:0]       t_in;
   logic [DW+TBITS:0]    m_ff [3];
   logic signed [DW-1:0] da_ff [3];
   logic signed [C-1:0]  qa_ff [3];
   region_type           ra_ff;
   logic signed [C-1:0]  nb_ff [3];
   logic [SW-1:0]        sqb_ff;
   region_type           rb_ff;
   logic signed [C-1:0]  n_in [3];
   logic [SW-1:0]        sq_in;
   assign t_in = eq_ff[TBITS] ? (TBITS+1)'(1) << TBITS : {1'b0, quo};
   always_comb begin
      sq_in = '0;
      for (int i = 0; i < 3; i++) begin
         logic [DW+TBITS:0]    rm;
         logic signed [DW-1:0] g;
         rm = (m_ff[i] + ((DW+TBITS+1)'(1) << (TBITS-1))) >> TBITS;
         case (ra_ff)
            REGION_BEFORE: n_in[i] = s_ff[i];
            REGION_PAST:   n_in[i] = e_ff[i];
            default: n_in[i] = da_ff[i] < 0 ? C'(s_ff[i] - C'(rm)) : C'(s_ff[i] + C'(rm));
         endcase
         g = DW'(qa_ff[i]) - DW'(n_in[i]);
         sq_in = sq_in + SW'($unsigned(PW'(g) * PW'(g)));
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            logic [DW-1:0] ad;
            ad = dd_ff[TBITS][i] < 0 ? DW'(-dd_ff[TBITS][i]) : DW'(dd_ff[TBITS][i]);
            m_ff[i]  <= {{(TBITS+1){1'b0}}, ad} * {{DW{1'b0}}, t_in};
            da_ff[i] <= dd_ff[TBITS][i];
            qa_ff[i] <= qq_ff[TBITS][i];
            nb_ff[i] <= n_in[i];
         end
         ra_ff  <= rg_ff[TBITS];
         rb_ff  <= ra_ff;
         sqb_ff <= sq_in;
      end
   end

   logic [RB-1:0] root;
   npseg_sqrt #(.W(SW), .RB(RB)) u_sqrt (
      .clock(clock), .advance(advance), .sq_in(sqb_ff), .root_out(root));

   logic signed [C-1:0] nn_ff [1:RB][3];
   region_type          rr_ff [1:RB];
   always_ff @(posedge clock) begin
      if (advance) begin
         nn_ff[1] <= nb_ff;
         rr_ff[1] <= rb_ff;
         for (int k = 1; k < RB; k++) begin
            nn_ff[k+1] <= nn_ff[k];
            rr_ff[k+1] <= rr_ff[k];
         end
      end
   end

   logic [DW-1:0] gap_in;
   assign gap_in = (root > RB'({DW{1'b1}})) ? {DW{1'b1}} : DW'(root);

   logic [TW-1:0] out_data_ff;
   logic [C+2:0]  out_user_ff;
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (advance) out_valid_ff <= vld_ff[LAT];
      if (advance) begin
         out_data_ff <= {nn_ff[RB][2], nn_ff[RB][1], nn_ff[RB][0]};
         out_user_ff <= {gap_in, rr_ff[RB]} | (C+3)'(FRAC_UNUSED & 0);
      end
   end
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = $bits(rsp_tdata)'(out_data_ff);
   assign rsp_tuser  = out_user_ff;

   region_out_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[1:0] != 2'd3)
      else $error("bad region");
   stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stall lost word");
   ready_follows: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("ready low while output empty");
endmodule

// File: tb/sv/tb.sv
// Testbench for nearest_point_on_segment_3d_unit: directed table plus random queries.
module tb;
   import npseg_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = 24;
   localparam int DW = ((3*CB+7)/8)*8;

   typedef struct packed {
      logic [CB-1:0] x, y, z;
      region_type    region;
      logic [CB:0]   gap;
   } near_t;

   typedef struct {
      logic [CB-1:0] qx, qy, qz;
      bit            typed;
      near_t         want;
   } dir_row_t;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [2:0] csr_index = '0;
   logic [CB-1:0] csr_wdata = '0;
   logic req_tvalid = 0;
   logic req_tready;
   logic [DW-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [DW-1:0] rsp_tdata;
   logic [CB+2:0] rsp_tuser;

   logic [CB-1:0] seg [6];
   near_t nearest_q [$];
   int errors = 0;
   bit rsp_stall_mode = 0;

   nearest_point_on_segment_3d_unit dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("nearest_point_on_segment_3d_unit verification failed");
      $finish;
   end

   function automatic logic signed [127:0] sx(logic [CB-1:0] v);
      return {{(128-CB){v[CB-1]}}, v};
   endfunction

   function automatic near_t project_point(logic [CB-1:0] qx, qy, qz);
      logic signed [127:0] s[3], e[3], q[3], d[3], n[3];
      logic signed [127:0] dot, len2, sq, rem, m, rm;
      logic [63:0] t, g;
      near_t r;
      s[0] = sx(seg[0]); s[1] = sx(seg[1]); s[2] = sx(seg[2]);
      e[0] = sx(seg[3]); e[1] = sx(seg[4]); e[2] = sx(seg[5]);
      q[0] = sx(qx); q[1] = sx(qy); q[2] = sx(qz);
      dot = 0; len2 = 0; sq = 0;
      for (int i = 0; i < 3; i++) begin
         d[i] = e[i] - s[i];
         dot += d[i] * (q[i] - s[i]);
         len2 += d[i] * d[i];
      end
      if (dot < 0) begin
         r.region = REGION_BEFORE;
         for (int i = 0; i < 3; i++) n[i] = s[i];
      end else if (dot > len2) begin
         r.region = REGION_PAST;
         for (int i = 0; i < 3; i++) n[i] = e[i];
      end else begin
         r.region = REGION_INSIDE;
         if (dot == len2) t = 64'd1 << TBITS;
         else begin
            t = 0; rem = dot;
            for (int k = 0; k < TBITS; k++) begin
               rem = rem <<< 1;
               t = t << 1;
               if (rem >= len2) begin
                  rem -= len2;
                  t[0] = 1;
               end
            end
         end
         for (int i = 0; i < 3; i++) begin
            m = (d[i] < 0 ? -d[i] : d[i]) * $signed({64'd0, t});
            rm = (m + (128'sd1 <<< (TBITS-1))) >>> TBITS;
            n[i] = d[i] < 0 ? s[i] - rm : s[i] + rm;
         end
      end
      for (int i = 0; i < 3; i++) sq += (q[i] - n[i]) * (q[i] - n[i]);
      g = 0;
      for (int b = 34; b >= 0; b--)
         if ($signed({64'd0, g | (64'd1 << b)}) * $signed({64'd0, g | (64'd1 << b)}) <= sq)
            g |= 64'd1 << b;
      if (g > (64'd1 << (CB+1)) - 1) g = (64'd1 << (CB+1)) - 1;
      r.x = n[0][CB-1:0]; r.y = n[1][CB-1:0]; r.z = n[2][CB-1:0];
      r.gap = g[CB:0];
      return r;
   endfunction

   task automatic write_seg(logic [2:0] idx, logic [CB-1:0] v);
      @(negedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= v;
      @(negedge clock);
      csr_we <= 0;
      if (idx < 6) seg[idx] = v;
   endtask

   task automatic set_segment(logic [CB-1:0] a[6]);
      write_seg(CSR_START_X, a[0]); write_seg(CSR_START_Y, a[1]);
      write_seg(CSR_START_Z, a[2]); write_seg(CSR_END_X, a[3]);
      write_seg(CSR_END_Y, a[4]); write_seg(CSR_END_Z, a[5]);
   endtask

   task automatic drain();
      int n;
      n = 0;
      req_tvalid <= 0;
      while (nearest_q.size() != 0 && n < 200000) begin
         @(negedge clock);
         n++;
      end
      repeat (120) @(negedge clock);
   endtask

   // sender: bursts with gaps; caller holds on falling edge
   task automatic send_query(logic [CB-1:0] qx, qy, qz, bit typed, near_t want);
      near_t p;
      p = project_point(qx, qy, qz);
      if (typed && p != want) begin
         $display("%0t table row disagrees with predictor: exp %h got %h", $time, want, p);
         errors++;
      end
      req_tvalid <= 1;
      req_tdata <= {qz, qy, qx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      nearest_q.push_back(typed ? want : p);
      @(negedge clock);
      if ($urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   always @(posedge clock) begin
      near_t got, exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.x = rsp_tdata[CB-1:0];
         got.y = rsp_tdata[2*CB-1:CB];
         got.z = rsp_tdata[3*CB-1:2*CB];
         got.region = region_type'(rsp_tuser[1:0]);
         got.gap = rsp_tuser[CB+2:2];
         if (nearest_q.size() == 0) begin
            $display("%0t unexpected word: got %h", $time, got);
            errors++;
         end else begin
            exp = nearest_q.pop_front();
            if (got.x !== exp.x) $display("%0t near_x exp %h got %h", $time, exp.x, got.x);
            if (got.y !== exp.y) $display("%0t near_y exp %h got %h", $time, exp.y, got.y);
            if (got.z !== exp.z) $display("%0t near_z exp %h got %h", $time, exp.z, got.z);
            if (got.region !== exp.region)
               $display("%0t region exp %0d got %0d", $time, exp.region, got.region);
            if (got.gap !== exp.gap) $display("%0t gap exp %h got %h", $time, exp.gap, got.gap);
            if (got !== exp) errors++;
         end
      end
   end

   always @(negedge clock) begin
      if ($urandom_range(0, 99) == 0) rsp_stall_mode = ~rsp_stall_mode;
      rsp_tready <= rsp_stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
   end

   function automatic logic [CB-1:0] rnd_coord();
      case ($urandom_range(0, 5))
         0: return 24'h800000;
         1: return 24'h7fffff;
         2: return 24'($urandom_range(0, 511)) - 24'd256;
         default: return 24'($urandom);
      endcase
   endfunction

   initial begin
      dir_row_t rows [$];
      logic [CB-1:0] sv6 [6];
      logic [CB-1:0] qx, qy, qz;
      near_t w;
      int unsigned lo_r;
      foreach (seg[i]) seg[i] = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // zero-length segment after reset: start point, inside
      w = '{x:0, y:0, z:0, region:REGION_INSIDE, gap:0};
      rows.push_back('{24'd0, 24'd0, 24'd0, 1, w});
      w = '{x:0, y:0, z:0, region:REGION_INSIDE, gap:25'd256};
      rows.push_back('{24'd256, 24'd0, 24'd0, 1, w});
      rows.push_back('{24'h800000, 24'h800000, 24'h800000, 0, w});
      rows.push_back('{24'h7fffff, 24'h800000, 24'h7fffff, 0, w});
      foreach (rows[i]) send_query(rows[i].qx, rows[i].qy, rows[i].qz, rows[i].typed,
                                   rows[i].want);
      drain();

      // segment along x from 0 to 1.0
      sv6 = '{24'd0, 24'd0, 24'd0, 24'd256, 24'd0, 24'd0};
      set_segment(sv6);
      rows.delete();
      w = '{x:0, y:0, z:0, region:REGION_BEFORE, gap:25'd256};
      rows.push_back('{24'hffff00, 24'd0, 24'd0, 1, w});
      w = '{x:24'd256, y:0, z:0, region:REGION_PAST, gap:25'd256};
      rows.push_back('{24'd512, 24'd0, 24'd0, 1, w});
      w = '{x:24'd128, y:0, z:0, region:REGION_INSIDE, gap:25'd256};
      rows.push_back('{24'd128, 24'd256, 24'd0, 1, w});
      w = '{x:24'd256, y:0, z:0, region:REGION_INSIDE, gap:25'd0};
      rows.push_back('{24'd256, 24'd0, 24'd0, 1, w});
      rows.push_back('{24'd77, 24'h800000, 24'h7fffff, 0, w});
      foreach (rows[i]) send_query(rows[i].qx, rows[i].qy, rows[i].qz, rows[i].typed,
                                   rows[i].want);
      drain();

      // extreme segment corners; ignored index
      sv6 = '{24'h800000, 24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 24'h7fffff};
      set_segment(sv6);
      write_seg(3'd6, 24'h123456);
      write_seg(3'd7, 24'hfedcba);
      send_query(24'h800000, 24'h800000, 24'h800000, 0, w);
      send_query(24'h7fffff, 24'h7fffff, 24'h7fffff, 0, w);
      send_query(24'h7fffff, 24'h800000, 24'h000001, 0, w);
      send_query(24'h800000, 24'h7fffff, 24'haaaaaa, 0, w);
      send_query(24'h555555, 24'hffffff, 24'h000000, 0, w);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         lo_r = $urandom_range(0, 2);
         foreach (sv6[i]) sv6[i] = lo_r == 0 ? 24'($urandom_range(0, 4095)) - 24'd2048
                                             : rnd_coord();
         set_segment(sv6);
         for (int k = 0; k < 80; k++) begin
            qx = $urandom_range(0, 1) ? 24'(32'(signed'(seg[0])) +
                 $urandom_range(0, 8191) - 4096) : rnd_coord();
            qy = rnd_coord(); qz = rnd_coord();
            if ($urandom_range(0, 3) != 0) begin
               qy = seg[1] + 24'($urandom_range(0, 1023)) - 24'd512;
               qz = seg[5] + 24'($urandom_range(0, 1023)) - 24'd512;
            end
            send_query(qx, qy, qz, 0, w);
            if ($urandom_range(0, 20) == 0) begin
               req_tvalid <= 0;
               repeat ($urandom_range(5, 30)) @(negedge clock);
            end
         end
         req_tvalid <= 0;
         drain();
      end

      req_tvalid <= 0;
      drain();
      if (errors == 0 && nearest_q.size() == 0) begin
         $display("nearest_point_on_segment_3d_unit verification clean");
      end else begin
         $display("nearest_point_on_segment_3d_unit verification failed");
      end
      $finish;
   end
endmodule
